// ----- sv/pump_ramp_pressure_controller_top_macros.svh -----
// Assertion helpers for the pump controller top level.
// Each macro expects clk_i and rst_ni in scope.
`ifndef PUMP_RAMP_PRESSURE_CONTROLLER_TOP_MACROS_SVH
`define PUMP_RAMP_PRESSURE_CONTROLLER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent
`define PRPC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent
`define PRPC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- sv/prpc_pkg.sv -----
`timescale 1ns / 1ps
package prpc_pkg;

  // Fixed point format of the setpoint
  localparam int RPM_FRAC_BITS = 4;
  localparam int SP_W          = 18;
  localparam int RPM_W         = 14;
  localparam int SAMPLE_W      = 27;
  localparam int TARGET_W      = 26;
  localparam int SHORT_W       = 27;
  localparam int TICK_W        = 10;
  localparam int GAIN_W        = 10;
  localparam int RAMP_T_W      = 11;
  localparam int STALL_T_W     = 22;
  localparam int TIMEOUT_W     = 12;
  localparam int CFG_IDX_W     = 3;
  localparam int CFG_DATA_W    = 26;

  // Ramp: 20 rpm per step, one step after more than 100 ms
  localparam logic [SP_W-1:0]     RAMP_STEP_FX     = SP_W'(20 << RPM_FRAC_BITS);
  localparam logic [RAMP_T_W-1:0] RAMP_INTERVAL_MS = 11'd100;
  localparam logic [STALL_T_W-1:0] MS_PER_SEC      = 22'd1000;

  // gain * shortfall * 16 / 100000 = (gain * shortfall / 2) / 3125
  localparam int PROD_W   = GAIN_W + SHORT_W;   // 37
  localparam int QUOT_IN_W = 30;                // clamped product, halved
  localparam int QUOT_W   = 19;
  localparam int RECIP_W  = 21;
  localparam int RECIP_SH = 32;
  localparam logic [RECIP_W-1:0]   DIV_RECIP = 21'd1374389; // floor(2^32 / 3125)
  localparam logic [QUOT_IN_W-1:0] DIV_DEN   = 30'd3125;

  typedef enum logic [2:0] {
    ST_RAMPING    = 3'd0,
    ST_SENSOR_ERR = 3'd1,
    ST_NO_SHORT   = 3'd2,
    ST_STALL      = 3'd3,
    ST_REGULATING = 3'd4
  } status_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_TICK_PERIOD_MS  = 3'd0,
    CFG_RAMP_START_RPM  = 3'd1,
    CFG_MIN_RPM         = 3'd2,
    CFG_MAX_RPM         = 3'd3,
    CFG_STALL_TIMEOUT   = 3'd4,
    CFG_TARGET_PRESSURE = 3'd5,
    CFG_GAIN            = 3'd6
  } cfg_idx_e;

  // Result fields carried down the pipeline
  typedef struct packed {
    logic            mode;
    status_e         status;
    logic [SP_W-1:0] setpoint;
  } ctl_t;

  typedef struct packed {
    ctl_t               ctl;
    logic [SHORT_W-1:0] shortfall;
  } s1_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic [QUOT_IN_W-1:0] dividend;
  } s2_t;

  typedef struct packed {
    ctl_t                 ctl;
    logic [QUOT_IN_W-1:0] dividend;
    logic [QUOT_W-1:0]    quot;
  } s3_t;

  typedef struct packed {
    ctl_t              ctl;
    logic [QUOT_W-1:0] quot;
    logic              round_up;
  } s4_t;

endpackage

// ----- sv/pump_ramp_pressure_controller_top.sv -----
`timescale 1ns / 1ps
// Pump ramp and pressure controller. Each transfer on the input channel is one control tick
// with two pressure samples; each produces exactly one result (setpoint in sixteenths of an
// rpm, mode, status) in order. A tick is taken every clock cycle when the output side keeps
// up; the result is offered after the five register stages of the path (input register
// with the shortfall, gain multiply, reciprocal multiply for the divide by 100000,
// remainder correction, then offset and cap). Mode, ramp and stall timers are updated in
// the cycle of the input transfer, so back-to-back ticks see each other's state.
// Configuration writes take effect at once and are meant for idle periods; writing the ramp
// start value in startup mode reloads the setpoint and restarts the ramp interval.
`include "pump_ramp_pressure_controller_top_macros.svh"
module pump_ramp_pressure_controller_top (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [prpc_pkg::CFG_IDX_W-1:0]        cfg_index_i,
  input  logic [prpc_pkg::CFG_DATA_W-1:0]       cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic signed [prpc_pkg::SAMPLE_W-1:0]  pressure_a_pa_i,
  input  logic signed [prpc_pkg::SAMPLE_W-1:0]  pressure_b_pa_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic [prpc_pkg::SP_W-1:0]             rpm_setpoint_o,
  output logic                                  mode_o,
  output logic [2:0]                            status_o
);

  // Configuration registers
  logic [prpc_pkg::TICK_W-1:0]    tick_ms_q;
  logic [prpc_pkg::RPM_W-1:0]     min_rpm_q;
  logic [prpc_pkg::RPM_W-1:0]     max_rpm_q;
  logic [prpc_pkg::STALL_T_W-1:0] stall_limit_q;
  logic [prpc_pkg::TARGET_W-1:0]  target_q;
  logic [prpc_pkg::GAIN_W-1:0]    gain_q;

  // Control state
  logic                           mode_q, mode_d;
  logic [prpc_pkg::SP_W-1:0]      sp_q, sp_d;
  logic [prpc_pkg::RAMP_T_W-1:0]  ramp_q, ramp_d;
  logic [prpc_pkg::STALL_T_W-1:0] stall_q, stall_d;

  // Pipeline
  logic          v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic          rdy1, rdy2, rdy3, rdy4, rdy_out;
  prpc_pkg::s1_t s1_q, s1_d;
  prpc_pkg::s2_t s2_q, s2_d;
  prpc_pkg::s3_t s3_q, s3_d;
  prpc_pkg::s4_t s4_q, s4_d;
  prpc_pkg::ctl_t out_q, out_d;

  logic                           in_xfer;
  logic [prpc_pkg::SP_W-1:0]      base_fx, cap_fx, ramp_sp;
  logic [prpc_pkg::RAMP_T_W:0]    ramp_sum;
  logic [prpc_pkg::RAMP_T_W-1:0]  ramp_nx;
  logic [prpc_pkg::STALL_T_W:0]   stall_sum;
  logic [prpc_pkg::STALL_T_W-1:0] stall_nx;
  logic [prpc_pkg::SP_W:0]        step_sum;
  logic [prpc_pkg::SP_W-1:0]      step_sp;
  logic                           sensor_err;
  logic [prpc_pkg::TARGET_W-1:0]  short_a, short_b;
  logic [prpc_pkg::SHORT_W-1:0]   shortfall;
  logic [prpc_pkg::PROD_W-1:0]    gain_prod;
  logic [30:0]                    prod_sat;
  logic [prpc_pkg::QUOT_IN_W+prpc_pkg::RECIP_W-1:0] recip_prod;
  logic [prpc_pkg::QUOT_IN_W-1:0] quot_back, rem;
  logic [prpc_pkg::QUOT_W:0]      inc;
  logic [prpc_pkg::QUOT_W+1:0]    reg_sum;

  assign base_fx = {min_rpm_q, prpc_pkg::RPM_FRAC_BITS'(0)};
  assign cap_fx  = {max_rpm_q, prpc_pkg::RPM_FRAC_BITS'(0)};

  // Handshake: each stage loads when empty or when the next stage loads
  assign rdy_out     = !out_v_q || out_ready_i;
  assign rdy4        = !v4_q || rdy_out;
  assign rdy3        = !v3_q || rdy4;
  assign rdy2        = !v2_q || rdy3;
  assign rdy1        = !v1_q || rdy2;
  assign in_ready_o  = rdy1;
  assign in_xfer     = in_valid_i && rdy1;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_ms_q     <= prpc_pkg::TICK_W'(10);
      min_rpm_q     <= prpc_pkg::RPM_W'(800);
      max_rpm_q     <= prpc_pkg::RPM_W'(1800);
      stall_limit_q <= prpc_pkg::STALL_T_W'(60000);
      target_q      <= prpc_pkg::TARGET_W'(1000000);
      gain_q        <= prpc_pkg::GAIN_W'(100);
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        prpc_pkg::CFG_TICK_PERIOD_MS:  tick_ms_q <= cfg_data_i[prpc_pkg::TICK_W-1:0];
        prpc_pkg::CFG_MIN_RPM:         min_rpm_q <= cfg_data_i[prpc_pkg::RPM_W-1:0];
        prpc_pkg::CFG_MAX_RPM:         max_rpm_q <= cfg_data_i[prpc_pkg::RPM_W-1:0];
        prpc_pkg::CFG_STALL_TIMEOUT: begin
          stall_limit_q <= prpc_pkg::STALL_T_W'(cfg_data_i[prpc_pkg::TIMEOUT_W-1:0])
                           * prpc_pkg::MS_PER_SEC;
        end
        prpc_pkg::CFG_TARGET_PRESSURE: target_q  <= cfg_data_i[prpc_pkg::TARGET_W-1:0];
        prpc_pkg::CFG_GAIN:            gain_q    <= cfg_data_i[prpc_pkg::GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturating timers and ramp step
  always_comb begin
    ramp_sum  = {1'b0, ramp_q} + (prpc_pkg::RAMP_T_W+1)'(tick_ms_q);
    ramp_nx   = ramp_sum[prpc_pkg::RAMP_T_W] ? '1 : ramp_sum[prpc_pkg::RAMP_T_W-1:0];
    stall_sum = {1'b0, stall_q} + (prpc_pkg::STALL_T_W+1)'(tick_ms_q);
    stall_nx  = stall_sum[prpc_pkg::STALL_T_W] ? '1 : stall_sum[prpc_pkg::STALL_T_W-1:0];
    step_sum  = {1'b0, sp_q} + {1'b0, prpc_pkg::RAMP_STEP_FX};
    step_sp   = step_sum[prpc_pkg::SP_W] ? '1 : step_sum[prpc_pkg::SP_W-1:0];
  end

  // Sensor check and summed shortfall against the target
  always_comb begin
    sensor_err = pressure_a_pa_i[prpc_pkg::SAMPLE_W-1] || pressure_b_pa_i[prpc_pkg::SAMPLE_W-1];
    short_a    = '0;
    short_b    = '0;
    if (pressure_a_pa_i[prpc_pkg::TARGET_W-1:0] < target_q) begin
      short_a = target_q - pressure_a_pa_i[prpc_pkg::TARGET_W-1:0];
    end
    if (pressure_b_pa_i[prpc_pkg::TARGET_W-1:0] < target_q) begin
      short_b = target_q - pressure_b_pa_i[prpc_pkg::TARGET_W-1:0];
    end
    shortfall = prpc_pkg::SHORT_W'(short_a) + prpc_pkg::SHORT_W'(short_b);
  end

  // Next state and first stage payload
  always_comb begin
    mode_d  = mode_q;
    sp_d    = sp_q;
    ramp_d  = ramp_q;
    stall_d = stall_q;
    ramp_sp = sp_q;
    s1_d.ctl.mode     = mode_q;
    s1_d.ctl.status   = prpc_pkg::ST_RAMPING;
    s1_d.ctl.setpoint = base_fx;
    s1_d.shortfall    = shortfall;
    if (in_xfer) begin
      ramp_d  = ramp_nx;
      stall_d = stall_nx;
      if (!mode_q) begin
        if (ramp_nx > prpc_pkg::RAMP_INTERVAL_MS) begin
          ramp_sp = step_sp;
          ramp_d  = '0;
        end
        if (ramp_sp >= base_fx) begin
          ramp_sp = base_fx;
          mode_d  = 1'b1;
        end
        sp_d              = ramp_sp;
        s1_d.ctl.mode     = mode_d;
        s1_d.ctl.setpoint = ramp_sp;
      end else if (sensor_err) begin
        s1_d.ctl.status = prpc_pkg::ST_SENSOR_ERR;
      end else if (shortfall == '0) begin
        stall_d         = '0;
        s1_d.ctl.status = prpc_pkg::ST_NO_SHORT;
      end else if (stall_nx > stall_limit_q) begin
        s1_d.ctl.status = prpc_pkg::ST_STALL;
      end else begin
        s1_d.ctl.status = prpc_pkg::ST_REGULATING;
      end
    end else if (cfg_we_i && cfg_index_i == prpc_pkg::CFG_RAMP_START_RPM && !mode_q) begin
      // Reload the ramp from the new start value
      sp_d   = {cfg_data_i[prpc_pkg::RPM_W-1:0], prpc_pkg::RPM_FRAC_BITS'(0)};
      ramp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      sp_q    <= '0;
      ramp_q  <= '0;
      stall_q <= '0;
    end else begin
      mode_q  <= mode_d;
      sp_q    <= sp_d;
      ramp_q  <= ramp_d;
      stall_q <= stall_d;
    end
  end

  // Stage 2: gain times shortfall, clamp (anything above hits the cap), halve
  always_comb begin
    gain_prod   = prpc_pkg::PROD_W'(s1_q.shortfall) * prpc_pkg::PROD_W'(gain_q);
    prod_sat    = (|gain_prod[prpc_pkg::PROD_W-1:31]) ? '1 : gain_prod[30:0];
    s2_d.ctl      = s1_q.ctl;
    s2_d.dividend = prod_sat[30:1];
  end

  // Stage 3: quotient estimate by reciprocal, low by at most one
  always_comb begin
    recip_prod    = (prpc_pkg::QUOT_IN_W+prpc_pkg::RECIP_W)'(s2_q.dividend)
                    * (prpc_pkg::QUOT_IN_W+prpc_pkg::RECIP_W)'(prpc_pkg::DIV_RECIP);
    s3_d.ctl      = s2_q.ctl;
    s3_d.dividend = s2_q.dividend;
    s3_d.quot     = recip_prod[prpc_pkg::RECIP_SH+prpc_pkg::QUOT_W-1:prpc_pkg::RECIP_SH];
  end

  // Stage 4: remainder check for the correction
  always_comb begin
    quot_back     = prpc_pkg::QUOT_IN_W'(s3_q.quot) * prpc_pkg::DIV_DEN;
    rem           = s3_q.dividend - quot_back;
    s4_d.ctl      = s3_q.ctl;
    s4_d.quot     = s3_q.quot;
    s4_d.round_up = (rem >= prpc_pkg::DIV_DEN);
  end

  // Output stage: offset by the base speed and cap
  always_comb begin
    inc     = (prpc_pkg::QUOT_W+1)'(s4_q.quot) + (prpc_pkg::QUOT_W+1)'(s4_q.round_up);
    reg_sum = (prpc_pkg::QUOT_W+2)'(base_fx) + (prpc_pkg::QUOT_W+2)'(inc);
    out_d   = s4_q.ctl;
    if (s4_q.ctl.status == prpc_pkg::ST_REGULATING) begin
      out_d.setpoint = (reg_sum > (prpc_pkg::QUOT_W+2)'(cap_fx)) ? cap_fx
                       : reg_sum[prpc_pkg::SP_W-1:0];
    end
  end

  // Advance valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (rdy1)    v1_q    <= in_valid_i;
      if (rdy2)    v2_q    <= v1_q;
      if (rdy3)    v3_q    <= v2_q;
      if (rdy4)    v4_q    <= v3_q;
      if (rdy_out) out_v_q <= v4_q;
    end
  end

  // Advance payloads
  always_ff @(posedge clk_i) begin
    if (in_xfer)          s1_q  <= s1_d;
    if (rdy2 && v1_q)     s2_q  <= s2_d;
    if (rdy3 && v2_q)     s3_q  <= s3_d;
    if (rdy4 && v3_q)     s4_q  <= s4_d;
    if (rdy_out && v4_q)  out_q <= out_d;
  end

  assign out_valid_o    = out_v_q;
  assign rpm_setpoint_o = out_q.setpoint;
  assign mode_o         = out_q.mode;
  assign status_o       = out_q.status;

  `PRPC_ASSERT_NEXT(a_mode_sticky, mode_q, mode_q, "control mode left")
  `PRPC_ASSERT_SAME(a_ctl_status_mode,
    out_valid_o && status_o != prpc_pkg::ST_RAMPING, mode_o,
    "control status outside control mode")
  `PRPC_ASSERT_SAME(a_reg_capped,
    out_valid_o && status_o == prpc_pkg::ST_REGULATING, rpm_setpoint_o <= cap_fx,
    "regulated setpoint above cap")

endmodule

// ----- dv/tb_top.sv -----
`timescale 1ns / 1ps
module tb_top;

  // Fixed point and timing constants of the controller
  localparam int          FRAC          = prpc_pkg::RPM_FRAC_BITS;
  localparam int unsigned RAMP_RISE_FX  = 20 << FRAC;
  localparam int unsigned RAMP_GAP_MS   = 100;
  localparam int unsigned RAMP_MS_MAX   = 11'h7FF;
  localparam int unsigned STALL_MS_MAX  = 22'h3FFFFF;
  localparam int unsigned SP_MAX        = 18'h3FFFF;
  localparam longint unsigned PA_PER_BAR = 100000;

  localparam logic [26:0] SAMPLE_MAX = 27'h3FFFFFF;
  localparam logic [26:0] SAMPLE_MIN = 27'h4000000;
  localparam logic [26:0] MINUS_ONE  = 27'h7FFFFFF;
  localparam logic [2:0]  CFG_UNUSED = 3'd7;

  localparam int N_PHASES        = 8;
  localparam int TICKS_PER_PHASE = 225;
  localparam int SETTLE_CYCLES   = 8;
  localparam int LIMIT_CYCLES    = 400000;

  typedef struct packed {
    logic [17:0]       setpoint;
    logic              mode;
    prpc_pkg::status_e status;
  } result_t;

  typedef enum {ROW_TICK, ROW_CFG} row_kind_e;
  typedef enum {RDY_OPEN, RDY_COIN, RDY_SPARSE, RDY_HOLD} ready_pattern_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  reg_idx;
    logic [25:0] reg_data;
    logic [26:0] a;
    logic [26:0] b;
    bit          typed;
    result_t     want;
  } dir_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_index_i = '0;
  logic [25:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic signed [26:0] pressure_a_pa_i = '0;
  logic signed [26:0] pressure_b_pa_i = '0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [17:0] rpm_setpoint_o;
  logic        mode_o;
  logic [2:0]  status_o;

  pump_ramp_pressure_controller_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .pressure_a_pa_i (pressure_a_pa_i),
    .pressure_b_pa_i (pressure_b_pa_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .rpm_setpoint_o  (rpm_setpoint_o),
    .mode_o          (mode_o),
    .status_o        (status_o)
  );

  // Mirror of the register file, reset values
  logic [9:0]  tick_ms_q      = 10'd10;
  logic [13:0] ramp_start_q   = 14'd0;
  logic [13:0] min_rpm_q      = 14'd800;
  logic [13:0] max_rpm_q      = 14'd1800;
  logic [11:0] timeout_s_q    = 12'd60;
  logic [25:0] target_pa_q    = 26'd1000000;
  logic [9:0]  gain_q         = 10'd100;

  // Mirror of the controller state
  logic        ctl_mode       = 1'b0;
  logic [17:0] ctl_setpoint   = '0;
  logic [10:0] ramp_ms        = '0;
  logic [21:0] stall_ms       = '0;

  result_t        pending_results[$];
  result_t        head_result;
  int             mismatch_count = 0;
  int             burst_left = 0;
  int             cycle_count = 0;
  ready_pattern_e rdy_pattern = RDY_OPEN;
  int             rdy_left = 0;

  // Directed ticks and register writes, expectations typed where obvious
  dir_row_t dir_rows [25] = '{
    '{ROW_TICK, '0, '0, SAMPLE_MAX, SAMPLE_MIN, 1'b1, '{18'd0, 1'b0, prpc_pkg::ST_RAMPING}},
    '{ROW_TICK, '0, '0, SAMPLE_MIN, SAMPLE_MAX, 1'b1, '{18'd0, 1'b0, prpc_pkg::ST_RAMPING}},
    '{ROW_TICK, '0, '0, 27'd0, 27'd0, 1'b1, '{18'd0, 1'b0, prpc_pkg::ST_RAMPING}},
    '{ROW_CFG, prpc_pkg::CFG_TICK_PERIOD_MS, 26'd100, '0, '0, 1'b0, '0},
    // interval passed: one rise of 20 rpm
    '{ROW_TICK, '0, '0, 27'd1000000, 27'd1000000, 1'b1,
      '{18'd320, 1'b0, prpc_pkg::ST_RAMPING}},
    // reload the ramp close to the minimum
    '{ROW_CFG, prpc_pkg::CFG_RAMP_START_RPM, 26'd790, '0, '0, 1'b0, '0},
    '{ROW_CFG, prpc_pkg::CFG_TICK_PERIOD_MS, 26'd1000, '0, '0, 1'b0, '0},
    // rise reaches the minimum: clamp and switch to control
    '{ROW_TICK, '0, '0, MINUS_ONE, MINUS_ONE, 1'b1,
      '{18'd12800, 1'b1, prpc_pkg::ST_RAMPING}},
    '{ROW_CFG, prpc_pkg::CFG_RAMP_START_RPM, 26'd0, '0, '0, 1'b0, '0},
    '{ROW_CFG, CFG_UNUSED, 26'h3FFFFFF, '0, '0, 1'b0, '0},
    '{ROW_TICK, '0, '0, MINUS_ONE, 27'd5, 1'b1, '{18'd12800, 1'b1, prpc_pkg::ST_SENSOR_ERR}},
    '{ROW_TICK, '0, '0, 27'd5, SAMPLE_MIN, 1'b1, '{18'd12800, 1'b1, prpc_pkg::ST_SENSOR_ERR}},
    '{ROW_TICK, '0, '0, SAMPLE_MAX, SAMPLE_MAX, 1'b1,
      '{18'd12800, 1'b1, prpc_pkg::ST_NO_SHORT}},
    '{ROW_TICK, '0, '0, 27'd999999, 27'd1000000, 1'b0, '0},
    '{ROW_TICK, '0, '0, 27'd0, 27'd0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 27'd900000, 27'd1000000, 1'b0, '0},
    '{ROW_CFG, prpc_pkg::CFG_STALL_TIMEOUT, 26'd1, '0, '0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 27'd0, 27'd0, 1'b1, '{18'd12800, 1'b1, prpc_pkg::ST_STALL}},
    // cap below the base
    '{ROW_CFG, prpc_pkg::CFG_MAX_RPM, 26'd500, '0, '0, 1'b0, '0},
    '{ROW_CFG, prpc_pkg::CFG_STALL_TIMEOUT, 26'd3600, '0, '0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 27'd0, 27'd0, 1'b0, '0},
    // frozen time
    '{ROW_CFG, prpc_pkg::CFG_TICK_PERIOD_MS, 26'd0, '0, '0, 1'b0, '0},
    '{ROW_CFG, prpc_pkg::CFG_GAIN, 26'd1023, '0, '0, 1'b0, '0},
    '{ROW_TICK, '0, '0, 27'd123456, 27'd2000000, 1'b0, '0},
    '{ROW_TICK, '0, '0, SAMPLE_MAX, 27'd0, 1'b0, '0}
  };

  function automatic logic [17:0] rpm_to_fx(logic [13:0] rpm);
    return 18'(rpm) << FRAC;
  endfunction

  // Advance the mirrored state by one tick and return the setpoint it yields
  function automatic result_t predict_tick(logic [26:0] a, logic [26:0] b);
    result_t         res;
    logic [17:0]     base;
    int unsigned     sum;
    longint unsigned short_pa;
    longint unsigned level;
    base = rpm_to_fx(min_rpm_q);
    sum = ramp_ms + tick_ms_q;
    ramp_ms = (sum > RAMP_MS_MAX) ? RAMP_MS_MAX[10:0] : sum[10:0];
    sum = stall_ms + tick_ms_q;
    stall_ms = (sum > STALL_MS_MAX) ? STALL_MS_MAX[21:0] : sum[21:0];
    if (!ctl_mode) begin
      if (ramp_ms > RAMP_GAP_MS) begin
        sum = ctl_setpoint + RAMP_RISE_FX;
        ctl_setpoint = (sum > SP_MAX) ? SP_MAX[17:0] : sum[17:0];
        ramp_ms = '0;
      end
      if (ctl_setpoint >= base) begin
        ctl_setpoint = base;
        ctl_mode = 1'b1;
      end
      res.status = prpc_pkg::ST_RAMPING;
    end else if (a[26] || b[26]) begin
      ctl_setpoint = base;
      res.status = prpc_pkg::ST_SENSOR_ERR;
    end else begin
      short_pa = 0;
      if (a < target_pa_q) short_pa += target_pa_q - a;
      if (b < target_pa_q) short_pa += target_pa_q - b;
      if (short_pa == 0) begin
        ctl_setpoint = base;
        stall_ms = '0;
        res.status = prpc_pkg::ST_NO_SHORT;
      end else if (longint'(stall_ms) > longint'(timeout_s_q) * 1000) begin
        ctl_setpoint = base;
        res.status = prpc_pkg::ST_STALL;
      end else begin
        level = base + ((longint'(gain_q) * short_pa) << FRAC) / PA_PER_BAR;
        if (level > rpm_to_fx(max_rpm_q)) level = rpm_to_fx(max_rpm_q);
        ctl_setpoint = level[17:0];
        res.status = prpc_pkg::ST_REGULATING;
      end
    end
    res.setpoint = ctl_setpoint;
    res.mode = ctl_mode;
    return res;
  endfunction

  // Pressure sample around the target: errors, full range, surplus, shortfall
  function automatic logic [26:0] sample_for(logic [25:0] tgt);
    int unsigned     pick;
    int unsigned     span;
    longint unsigned v;
    pick = $urandom_range(0, 99);
    if (pick < 4) return {1'b1, 26'($urandom())};
    if (pick < 14) return 27'($urandom());
    if (pick < 45) begin
      v = longint'(tgt) + $urandom_range(0, 2000);
      return (v > SAMPLE_MAX) ? SAMPLE_MAX : 27'(v);
    end
    case ($urandom_range(0, 2))
      0: span = 20;
      1: span = 200000;
      default: span = tgt;
    endcase
    if (span > tgt) span = tgt;
    return 27'(tgt - $urandom_range(0, span));
  endfunction

  // Register value for a phase: all ones first, then floor, then random mixes
  function automatic logic [25:0] reg_value(int ph, int idx);
    logic [25:0] mask;
    logic [25:0] v;
    int unsigned hi;
    int unsigned pick;
    case (idx)
      prpc_pkg::CFG_TICK_PERIOD_MS:  begin mask = 26'h3FF;     hi = 1000;     end
      prpc_pkg::CFG_STALL_TIMEOUT:   begin mask = 26'hFFF;     hi = 3600;     end
      prpc_pkg::CFG_TARGET_PRESSURE: begin mask = 26'h3FFFFFF; hi = 50000000; end
      prpc_pkg::CFG_GAIN:            begin mask = 26'h3FF;     hi = 1000;     end
      default:                       begin mask = 26'h3FFF;    hi = 10000;    end
    endcase
    if (ph == 0) return mask;
    if (ph == 1)
      return (idx == prpc_pkg::CFG_TICK_PERIOD_MS || idx == prpc_pkg::CFG_STALL_TIMEOUT)
             ? 26'd1 : 26'd0;
    pick = $urandom_range(0, 9);
    case (pick)
      0: v = '0;
      1: v = mask;
      2: v = 26'(hi);
      default: v = 26'($urandom_range(0, hi));
    endcase
    // short timeouts so that the stall path fires
    if (idx == prpc_pkg::CFG_STALL_TIMEOUT && pick > 5) v = 26'($urandom_range(1, 5));
    // junk above the register width
    if ($urandom_range(0, 7) == 0) v |= 26'($urandom()) & ~mask;
    return v;
  endfunction

  // Drop valid, drain every pending setpoint, then let the pipeline settle
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Write one register and mirror it
  task automatic write_reg(input logic [2:0] idx, input logic [25:0] data);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    case (idx)
      prpc_pkg::CFG_TICK_PERIOD_MS: tick_ms_q = data[9:0];
      prpc_pkg::CFG_RAMP_START_RPM: begin
        ramp_start_q = data[13:0];
        if (!ctl_mode) begin
          ctl_setpoint = rpm_to_fx(ramp_start_q);
          ramp_ms = '0;
        end
      end
      prpc_pkg::CFG_MIN_RPM:         min_rpm_q = data[13:0];
      prpc_pkg::CFG_MAX_RPM:         max_rpm_q = data[13:0];
      prpc_pkg::CFG_STALL_TIMEOUT:   timeout_s_q = data[11:0];
      prpc_pkg::CFG_TARGET_PRESSURE: target_pa_q = data[25:0];
      prpc_pkg::CFG_GAIN:            gain_q = data[9:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
  endtask

  // Offer one tick in bursts; predict at the transfer
  task automatic send_tick(input logic [26:0] a, input logic [26:0] b,
                           input bit typed, input result_t want);
    result_t predicted;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
      burst_left = $urandom_range(1, 48);
    end
    burst_left--;
    in_valid_i      <= 1'b1;
    pressure_a_pa_i <= a;
    pressure_b_pa_i <= b;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    predicted = predict_tick(a, b);
    pending_results.push_back(typed ? want : predicted);
  endtask

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Abort a hung run
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // Check each output transfer and drive the receiver stall pattern
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("unexpected setpoint %0d mode %0d status %0d",
                   rpm_setpoint_o, mode_o, status_o);
      end else begin
        head_result = pending_results.pop_front();
        if (head_result.setpoint !== rpm_setpoint_o || head_result.mode !== mode_o ||
            head_result.status !== status_o) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("setpoint %0d/%0d mode %0d/%0d status %0d/%0d (expected/actual)",
                     head_result.setpoint, rpm_setpoint_o, head_result.mode, mode_o,
                     head_result.status, status_o);
        end
      end
    end
    if (rdy_left == 0) begin
      rdy_pattern = ready_pattern_e'($urandom_range(0, 3));
      rdy_left = $urandom_range(8, 80);
    end
    rdy_left--;
    case (rdy_pattern)
      RDY_OPEN:   out_ready_i <= 1'b1;
      RDY_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
      RDY_SPARSE: out_ready_i <= ($urandom_range(0, 3) == 0);
      default:    out_ready_i <= 1'b0;
    endcase
  end

  // Reset, directed table, random phases, drain and verdict
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(dir_rows[i].reg_idx, dir_rows[i].reg_data);
      end else begin
        send_tick(dir_rows[i].a, dir_rows[i].b, dir_rows[i].typed, dir_rows[i].want);
      end
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      for (int r = prpc_pkg::CFG_TICK_PERIOD_MS; r <= prpc_pkg::CFG_GAIN; r++) begin
        wait_idle();
        write_reg(3'(r), reg_value(ph, r));
      end
      if ($urandom_range(0, 3) == 0) begin
        wait_idle();
        write_reg(CFG_UNUSED, 26'($urandom()));
      end
      for (int n = 0; n < TICKS_PER_PHASE; n++)
        send_tick(sample_for(target_pa_q), sample_for(target_pa_q), 1'b0, '0);
    end

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
